// ===== rtl/spt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority task table package
// Shared types and codes for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package spt_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_MARK   = 2'd2,
    ACT_DUMP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    WR_NONE     = 3'd0,
    WR_SHIFT_UP = 3'd1,
    WR_SHIFT_DN = 3'd2,
    WR_NEW_NEXT = 3'd3,
    WR_NEW_HEAD = 3'd4,
    WR_MARK     = 3'd5
  } wr_sel_e;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic        done;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    step;
    wr_sel_e wr;
    logic    set_found;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    emit_entry;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pend_valid;
    logic pend_first;
    logic pend_last;
    logic hit;
    logic after;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/spt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface spt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] task_id;
  logic [7:0]  priority_req;

  modport source (output valid, action, task_id, priority_req, input ready);
  modport sink (input valid, action, task_id, priority_req, output ready);
endinterface

// ===== rtl/spt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface spt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] entry_id;
  logic [7:0]  entry_priority;
  logic        entry_done;
  logic        last;

  modport source (output valid, status, entry_id, entry_priority, entry_done, last,
                  input ready);
  modport sink (input valid, status, entry_id, entry_priority, entry_done, last,
                output ready);
endinterface

// ===== rtl/spt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority task table datapath
// Entry RAM, scan pointers, entry count, request and result registers.
// ----------------------------------------------------------------------------
module spt_datapath #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       action_i,
  input  logic [15:0]      task_id_i,
  input  logic [7:0]       priority_req_i,
  input  spt_pkg::dp_cmd_t cmd_i,
  output spt_pkg::dp_stat_t stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      entry_id_o,
  output logic [7:0]       entry_priority_o,
  output logic             entry_done_o,
  output logic             last_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(spt_pkg::entry_t);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q;
  logic [IW-1:0] rd_idx_q;
  logic [IW-1:0] pend_idx_q;
  logic          pend_valid_q;
  logic          found_q;
  logic          down_q;
  logic [15:0]   req_id_q;
  logic [7:0]    req_pr_q;

  logic          out_valid_q;
  spt_pkg::status_e out_status_q;
  logic [15:0]   out_id_q;
  logic [7:0]    out_pr_q;
  logic          out_done_q;
  logic          out_last_q;

  logic          rd_go;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  spt_pkg::entry_t wr_data;
  spt_pkg::entry_t rd_entry;
  spt_pkg::entry_t new_entry;
  logic [EW-1:0] rd_raw;
  logic          out_free;
  logic          pend_last;

  spt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_go),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_raw)
  );

  assign rd_entry  = spt_pkg::entry_t'(rd_raw);
  assign new_entry = '{id: req_id_q, prio: req_pr_q, done: 1'b0};
  assign out_free  = !out_valid_q || out_ready_i;
  assign pend_last = ((CW'(pend_idx_q) + CW'(1)) == count_q);
  assign rd_go     = cmd_i.scan && (rem_q != '0) && (!pend_valid_q || cmd_i.step);

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pend_idx_q + IW'(1);
    wr_data = rd_entry;
    case (cmd_i.wr)
      spt_pkg::WR_SHIFT_UP: begin
        wr_addr = pend_idx_q + IW'(1);
      end
      spt_pkg::WR_SHIFT_DN: begin
        wr_addr = pend_idx_q - IW'(1);
      end
      spt_pkg::WR_NEW_NEXT: begin
        wr_data = new_entry;
      end
      spt_pkg::WR_NEW_HEAD: begin
        wr_addr = '0;
        wr_data = new_entry;
      end
      spt_pkg::WR_MARK: begin
        wr_addr      = pend_idx_q;
        wr_data.done = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      rem_q        <= '0;
      pend_valid_q <= 1'b0;
      found_q      <= 1'b0;
      down_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        rem_q        <= count_q;
        pend_valid_q <= 1'b0;
        found_q      <= 1'b0;
        down_q       <= (spt_pkg::action_e'(action_i) == spt_pkg::ACT_INSERT);
      end else begin
        if (rd_go) begin
          rem_q        <= rem_q - CW'(1);
          pend_valid_q <= 1'b1;
        end else if (cmd_i.step) begin
          pend_valid_q <= 1'b0;
        end
        if (cmd_i.set_found) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_id_q <= task_id_i;
      req_pr_q <= priority_req_i;
      if (spt_pkg::action_e'(action_i) == spt_pkg::ACT_INSERT) begin
        rd_idx_q <= IW'(count_q - CW'(1));
      end else begin
        rd_idx_q <= '0;
      end
    end else if (rd_go) begin
      pend_idx_q <= rd_idx_q;
      rd_idx_q   <= down_q ? (rd_idx_q - IW'(1)) : (rd_idx_q + IW'(1));
    end
    if (cmd_i.emit) begin
      if (cmd_i.emit_entry) begin
        out_status_q <= spt_pkg::ST_OK;
        out_id_q     <= rd_entry.id;
        out_pr_q     <= rd_entry.prio;
        out_done_q   <= rd_entry.done;
        out_last_q   <= pend_last;
      end else begin
        out_status_q <= cmd_i.code;
        out_id_q     <= req_id_q;
        out_pr_q     <= '0;
        out_done_q   <= 1'b0;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(DEPTH));
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.pend_first = (pend_idx_q == '0);
  assign stat_o.pend_last  = pend_last;
  assign stat_o.hit        = (rd_entry.id == req_id_q);
  assign stat_o.after      = (rd_entry.prio > req_pr_q);
  assign stat_o.found      = found_q;
  assign stat_o.out_free   = out_free;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign entry_id_o       = out_id_q;
  assign entry_priority_o = out_pr_q;
  assign entry_done_o     = out_done_q;
  assign last_o           = out_last_q;

endmodule

// ===== rtl/spt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority task table controller
// Sequences the table scans for insert, delete, mark and dump.
// ----------------------------------------------------------------------------
module spt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_action_i,
  output logic              in_ready_o,
  input  spt_pkg::dp_stat_t stat_i,
  output spt_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS      = 7'b0000010,
    S_INS_HEAD = 7'b0000100,
    S_DEL      = 7'b0001000,
    S_MARK     = 7'b0010000,
    S_DUMP     = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  spt_pkg::status_e code_q, code_d;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.wr   = spt_pkg::WR_NONE;
    cmd_o.code = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          code_d     = spt_pkg::ST_OK;
          case (spt_pkg::action_e'(in_action_i))
            spt_pkg::ACT_INSERT: begin
              if (stat_i.full) begin
                code_d  = spt_pkg::ST_FULL;
                state_d = S_RESP;
              end else if (stat_i.empty) begin
                state_d = S_INS_HEAD;
              end else begin
                state_d = S_INS;
              end
            end
            spt_pkg::ACT_DELETE: begin
              if (stat_i.empty) begin
                code_d  = spt_pkg::ST_NOT_FOUND;
                state_d = S_RESP;
              end else begin
                state_d = S_DEL;
              end
            end
            spt_pkg::ACT_MARK: begin
              if (stat_i.empty) begin
                code_d  = spt_pkg::ST_NOT_FOUND;
                state_d = S_RESP;
              end else begin
                state_d = S_MARK;
              end
            end
            default: begin
              if (stat_i.empty) begin
                code_d  = spt_pkg::ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_DUMP;
              end
            end
          endcase
        end
      end
      S_INS: begin
        cmd_o.scan = 1'b1;
        if (stat_i.pend_valid) begin
          cmd_o.step = 1'b1;
          if (stat_i.after) begin
            cmd_o.wr = spt_pkg::WR_SHIFT_UP;
            if (stat_i.pend_first) begin
              state_d = S_INS_HEAD;
            end
          end else begin
            cmd_o.wr      = spt_pkg::WR_NEW_NEXT;
            cmd_o.cnt_inc = 1'b1;
            code_d        = spt_pkg::ST_OK;
            state_d       = S_RESP;
          end
        end
      end
      S_INS_HEAD: begin
        cmd_o.wr      = spt_pkg::WR_NEW_HEAD;
        cmd_o.cnt_inc = 1'b1;
        code_d        = spt_pkg::ST_OK;
        state_d       = S_RESP;
      end
      S_DEL: begin
        cmd_o.scan = 1'b1;
        if (stat_i.pend_valid) begin
          cmd_o.step = 1'b1;
          if (!stat_i.found && stat_i.hit) begin
            cmd_o.set_found = 1'b1;
          end
          if (stat_i.found) begin
            cmd_o.wr = spt_pkg::WR_SHIFT_DN;
          end
          if (stat_i.pend_last) begin
            state_d = S_RESP;
            if (stat_i.found || stat_i.hit) begin
              cmd_o.cnt_dec = 1'b1;
              code_d        = spt_pkg::ST_OK;
            end else begin
              code_d = spt_pkg::ST_NOT_FOUND;
            end
          end
        end
      end
      S_MARK: begin
        cmd_o.scan = 1'b1;
        if (stat_i.pend_valid) begin
          cmd_o.step = 1'b1;
          if (stat_i.hit) begin
            cmd_o.wr = spt_pkg::WR_MARK;
            code_d   = spt_pkg::ST_OK;
            state_d  = S_RESP;
          end else if (stat_i.pend_last) begin
            code_d  = spt_pkg::ST_NOT_FOUND;
            state_d = S_RESP;
          end
        end
      end
      S_DUMP: begin
        cmd_o.scan = 1'b1;
        if (stat_i.pend_valid && stat_i.out_free) begin
          cmd_o.step       = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.emit_entry = 1'b1;
          if (stat_i.pend_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= spt_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/sorted_priority_task_table.sv =====
`timescale 1ns / 1ps
// An insert, delete or mark returns one result item; a dump delivers one entry per cycle
// while the result channel is free to take it.
// One item is handled at a time: a new request is not taken before the last is through,
// and the scan of the entry RAM goes through its single read port and single write port.
// Reset clears the entry count and all control state; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Sorted priority task table
// Bounded table of task entries kept in ascending priority order.
// ----------------------------------------------------------------------------
module sorted_priority_task_table #(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spt_in_if.sink     in_i,
  spt_out_if.source  out_o
);

  spt_pkg::dp_cmd_t  cmd;
  spt_pkg::dp_stat_t stat;
  logic              in_ready;

  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (in_i.action),
    .task_id_i        (in_i.task_id),
    .priority_req_i   (in_i.priority_req),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .status_o         (out_o.status),
    .entry_id_o       (out_o.entry_id),
    .entry_priority_o (out_o.entry_priority),
    .entry_done_o     (out_o.entry_done),
    .last_o           (out_o.last)
  );

  assign in_i.ready = in_ready;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("Result emitted while the output register is occupied.");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !stat.full)
    else $error("Entry count incremented on a full table.");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> !stat.empty)
    else $error("Entry count decremented on an empty table.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("Request accepted while the previous item is still in progress.");

endmodule
